>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define QRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define QRM_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/qrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared constants and helpers of the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int ENTRY_BITS         = 16;
  localparam int ONE_Q14            = 16384;
  localparam int QUOT_BITS          = 16;
  localparam int NUM_ENTRIES        = 9;
  localparam int NUM_PRODUCTS       = 10;
  localparam int DIV_STAGES         = 4;
  localparam int MAX_COMP_BITS      = 30;

  // Components wider than 30 bits are cut down to 30 bits
  function automatic int narrow_bits(input int cb);
    return (cb > MAX_COMP_BITS) ? MAX_COMP_BITS : cb;
  endfunction

endpackage

>>> hw/rtl/qrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_quat_if / qrm_mat_if
// Valid/ready channels carrying a quaternion in and a rotation matrix out.
// ----------------------------------------------------------------------------
interface qrm_quat_if #(parameter int CB = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] quat_x;
  logic signed [CB-1:0] quat_y;
  logic signed [CB-1:0] quat_z;
  logic signed [CB-1:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrm_mat_if import qrm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [ENTRY_BITS-1:0] row0_col0;
  logic signed [ENTRY_BITS-1:0] row0_col1;
  logic signed [ENTRY_BITS-1:0] row0_col2;
  logic signed [ENTRY_BITS-1:0] row1_col0;
  logic signed [ENTRY_BITS-1:0] row1_col1;
  logic signed [ENTRY_BITS-1:0] row1_col2;
  logic signed [ENTRY_BITS-1:0] row2_col0;
  logic signed [ENTRY_BITS-1:0] row2_col1;
  logic signed [ENTRY_BITS-1:0] row2_col2;
  logic                         degenerate;
  modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, degenerate, input ready);
  modport sink   (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, degenerate, output ready);
endinterface

>>> hw/rtl/qrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_front
// Two pipeline stages: component products, then squared norm and the nine
// numerator magnitudes with their signs.
// ----------------------------------------------------------------------------
module qrm_front import qrm_pkg::*; #(
  parameter int CB = COMPONENT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  valid_i,
  input  logic signed [CB-1:0]                  x_i,
  input  logic signed [CB-1:0]                  y_i,
  input  logic signed [CB-1:0]                  z_i,
  input  logic signed [CB-1:0]                  w_i,
  output logic                                  valid_o,
  output logic [2*narrow_bits(CB):0]            den_o,
  output logic [2*narrow_bits(CB):0]            mag_o [NUM_ENTRIES],
  output logic                                  neg_o [NUM_ENTRIES],
  output logic                                  degen_o
);

  localparam int CN = narrow_bits(CB);
  localparam int SH = CB - CN;
  localparam int PW = 2 * CN;
  localparam int DW = PW + 1;
  localparam int NW = PW + 2;

  logic signed [CB-1:0] xs, ys, zs, ws;
  logic signed [PW-1:0] xe, ye, ze, we;
  logic signed [PW-1:0] prod_nxt [NUM_PRODUCTS];
  logic signed [PW-1:0] prod_r   [NUM_PRODUCTS];
  logic                 v1_r;
  logic signed [NW-1:0] num [NUM_ENTRIES];
  logic signed [NW-1:0] p   [NUM_PRODUCTS];
  logic signed [NW-1:0] norm;
  logic [DW-1:0]        mag_nxt [NUM_ENTRIES];
  logic                 neg_nxt [NUM_ENTRIES];
  logic [DW-1:0]        mag_r   [NUM_ENTRIES];
  logic                 neg_r   [NUM_ENTRIES];
  logic [DW-1:0]        den_r;
  logic                 degen_r;
  logic                 v2_r;

  // Narrow wide components (floor shift), then extend for the products
  always_comb begin
    xs = x_i >>> SH;
    ys = y_i >>> SH;
    zs = z_i >>> SH;
    ws = w_i >>> SH;
    xe = PW'($signed(xs[CN-1:0]));
    ye = PW'($signed(ys[CN-1:0]));
    ze = PW'($signed(zs[CN-1:0]));
    we = PW'($signed(ws[CN-1:0]));
    prod_nxt[0] = xe * xe;
    prod_nxt[1] = ye * ye;
    prod_nxt[2] = ze * ze;
    prod_nxt[3] = we * we;
    prod_nxt[4] = xe * ye;
    prod_nxt[5] = xe * ze;
    prod_nxt[6] = ye * ze;
    prod_nxt[7] = we * xe;
    prod_nxt[8] = we * ye;
    prod_nxt[9] = we * ze;
  end

  // Form the numerators and the squared norm
  always_comb begin
    for (int k = 0; k < NUM_PRODUCTS; k++) begin
      p[k] = NW'(prod_r[k]);
    end
    norm   = p[0] + p[1] + p[2] + p[3];
    num[0] = p[3] + p[0] - p[1] - p[2];
    num[1] = (p[4] - p[9]) <<< 1;
    num[2] = (p[5] + p[8]) <<< 1;
    num[3] = (p[4] + p[9]) <<< 1;
    num[4] = p[3] - p[0] + p[1] - p[2];
    num[5] = (p[6] - p[7]) <<< 1;
    num[6] = (p[5] - p[8]) <<< 1;
    num[7] = (p[6] + p[7]) <<< 1;
    num[8] = p[3] - p[0] - p[1] + p[2];
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      neg_nxt[k] = num[k][NW-1];
      mag_nxt[k] = neg_nxt[k] ? DW'(-num[k]) : DW'(num[k]);
    end
  end

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
    if (en) begin
      prod_r  <= prod_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      den_r   <= norm[DW-1:0];
      degen_r <= (norm == '0);
    end
  end

  assign valid_o = v2_r;
  assign den_o   = den_r;
  assign mag_o   = mag_r;
  assign neg_o   = neg_r;
  assign degen_o = degen_r;

endmodule

>>> hw/rtl/qrm_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_div_stage
// One register stage of the restoring divider, STEPS quotient bits for each
// of the nine entries. The first stage also takes the integer bit.
// ----------------------------------------------------------------------------
module qrm_div_stage import qrm_pkg::*; #(
  parameter int CB    = COMPONENT_BITS_DEF,
  parameter bit FIRST = 1'b0,
  parameter int STEPS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [2*narrow_bits(CB):0]    den_i,
  input  logic [2*narrow_bits(CB)+1:0]  rem_i [NUM_ENTRIES],
  input  logic [QUOT_BITS-1:0]          q_i   [NUM_ENTRIES],
  input  logic                          neg_i [NUM_ENTRIES],
  input  logic                          degen_i,
  output logic                          valid_o,
  output logic [2*narrow_bits(CB):0]    den_o,
  output logic [2*narrow_bits(CB)+1:0]  rem_o [NUM_ENTRIES],
  output logic [QUOT_BITS-1:0]          q_o   [NUM_ENTRIES],
  output logic                          neg_o [NUM_ENTRIES],
  output logic                          degen_o
);

  localparam int DW = 2 * narrow_bits(CB) + 1;
  localparam int RW = DW + 1;

  logic [RW-1:0]        rem_nxt [NUM_ENTRIES];
  logic [QUOT_BITS-1:0] q_nxt   [NUM_ENTRIES];
  logic [RW-1:0]        rem_r   [NUM_ENTRIES];
  logic [QUOT_BITS-1:0] q_r     [NUM_ENTRIES];
  logic                 neg_r   [NUM_ENTRIES];
  logic [DW-1:0]        den_r;
  logic                 degen_r;
  logic                 valid_r;

  // Compare and subtract, one quotient bit a step
  always_comb begin
    logic [RW-1:0]        r;
    logic [QUOT_BITS-1:0] q;
    logic [RW-1:0]        d;
    d = RW'(den_i);
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      r = rem_i[k];
      q = q_i[k];
      if (FIRST) begin
        if (r >= d) begin
          q = QUOT_BITS'(1);
          r = r - d;
          if (r >= d) begin
            r = '0;
          end
        end else begin
          q = '0;
        end
      end
      for (int s = 0; s < STEPS; s++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | QUOT_BITS'(1);
        end
      end
      rem_nxt[k] = r;
      q_nxt[k]   = q;
    end
  end

  // Hold the lane state in step with the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      neg_r   <= neg_i;
      den_r   <= den_i;
      degen_r <= degen_i;
    end
  end

  assign valid_o = valid_r;
  assign den_o   = den_r;
  assign rem_o   = rem_r;
  assign q_o     = q_r;
  assign neg_o   = neg_r;
  assign degen_o = degen_r;

endmodule

>>> hw/rtl/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Quaternion in Q3.12 to the nine 3x3 rotation matrix entries in Q1.14,
// normalised by division by the squared norm.
// ----------------------------------------------------------------------------
// One quaternion is taken per clock cycle unless the output stalls. It passes
// through one stage of component products, one of norm and numerators, four
// divider stages producing the sixteen quotient bits of all nine entries in
// parallel, and an output register that rounds and saturates. The whole pipe
// stalls together while the output transaction waits. A zero quaternion gives
// the identity matrix with degenerate set.
module quaternion_to_rotation_matrix import qrm_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qrm_quat_if.sink    in_quat,
  qrm_mat_if.source   out_mat
);

  localparam int DW = 2 * narrow_bits(COMPONENT_BITS) + 1;
  localparam int RW = DW + 1;

  logic                 en;
  logic                 out_valid_r;
  logic                 front_valid;
  logic [DW-1:0]        front_den;
  logic [DW-1:0]        front_mag [NUM_ENTRIES];
  logic                 front_neg [NUM_ENTRIES];
  logic                 front_degen;

  logic                 valid_s [DIV_STAGES+1];
  logic [DW-1:0]        den_s   [DIV_STAGES+1];
  logic [RW-1:0]        rem_s   [DIV_STAGES+1][NUM_ENTRIES];
  logic [QUOT_BITS-1:0] q_s     [DIV_STAGES+1][NUM_ENTRIES];
  logic                 neg_s   [DIV_STAGES+1][NUM_ENTRIES];
  logic                 degen_s [DIV_STAGES+1];

  logic signed [ENTRY_BITS-1:0] ent_nxt [NUM_ENTRIES];
  logic signed [ENTRY_BITS-1:0] ent_r   [NUM_ENTRIES];
  logic                         degen_r;

  // Advance the whole pipe unless the output transaction is stalled
  assign en            = !out_valid_r || out_mat.ready;
  assign in_quat.ready = en;

  qrm_front #(.CB(COMPONENT_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_quat.valid),
    .x_i     (in_quat.quat_x),
    .y_i     (in_quat.quat_y),
    .z_i     (in_quat.quat_z),
    .w_i     (in_quat.quat_w),
    .valid_o (front_valid),
    .den_o   (front_den),
    .mag_o   (front_mag),
    .neg_o   (front_neg),
    .degen_o (front_degen)
  );

  // Seed the divider with the numerator magnitudes
  always_comb begin
    valid_s[0] = front_valid;
    den_s[0]   = front_den;
    degen_s[0] = front_degen;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      rem_s[0][k] = RW'(front_mag[k]);
      q_s[0][k]   = '0;
      neg_s[0][k] = front_neg[k];
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    qrm_div_stage #(
      .CB    (COMPONENT_BITS),
      .FIRST (g == 0),
      .STEPS ((g == 0) ? QUOT_BITS / DIV_STAGES - 1 : QUOT_BITS / DIV_STAGES)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_s[g]),
      .den_i   (den_s[g]),
      .rem_i   (rem_s[g]),
      .q_i     (q_s[g]),
      .neg_i   (neg_s[g]),
      .degen_i (degen_s[g]),
      .valid_o (valid_s[g+1]),
      .den_o   (den_s[g+1]),
      .rem_o   (rem_s[g+1]),
      .q_o     (q_s[g+1]),
      .neg_o   (neg_s[g+1]),
      .degen_o (degen_s[g+1])
    );
  end

  // Round half away from zero, saturate, apply sign; identity when degenerate
  always_comb begin
    logic [QUOT_BITS:0]   qr;
    logic [QUOT_BITS-1:0] mag;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      qr  = ((QUOT_BITS + 1)'(q_s[DIV_STAGES][k]) + (QUOT_BITS + 1)'(1)) >> 1;
      mag = (qr > (QUOT_BITS + 1)'(ONE_Q14)) ? QUOT_BITS'(ONE_Q14) : qr[QUOT_BITS-1:0];
      if (degen_s[DIV_STAGES]) begin
        ent_nxt[k] = (k % 4 == 0) ? ENTRY_BITS'(ONE_Q14) : '0;
      end else if (neg_s[DIV_STAGES][k]) begin
        ent_nxt[k] = ENTRY_BITS'(-$signed({1'b0, mag}));
      end else begin
        ent_nxt[k] = ENTRY_BITS'(mag);
      end
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_s[DIV_STAGES];
    end
    if (en) begin
      ent_r   <= ent_nxt;
      degen_r <= degen_s[DIV_STAGES];
    end
  end

  assign out_mat.valid      = out_valid_r;
  assign out_mat.row0_col0  = ent_r[0];
  assign out_mat.row0_col1  = ent_r[1];
  assign out_mat.row0_col2  = ent_r[2];
  assign out_mat.row1_col0  = ent_r[3];
  assign out_mat.row1_col1  = ent_r[4];
  assign out_mat.row1_col2  = ent_r[5];
  assign out_mat.row2_col0  = ent_r[6];
  assign out_mat.row2_col1  = ent_r[7];
  assign out_mat.row2_col2  = ent_r[8];
  assign out_mat.degenerate = degen_r;

endmodule

>>> hw/rtl/qrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_checker
// Port-level assertions on the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qrm_checker import qrm_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_degen,
  input logic [8:0][ENTRY_BITS-1:0] ent
);

  // Every entry lies within plus or minus one
  function automatic logic all_in_range(input logic [8:0][ENTRY_BITS-1:0] e);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 9; k++) begin
      ok = ok && ($signed(e[k]) >= -ONE_Q14) && ($signed(e[k]) <= ONE_Q14);
    end
    return ok;
  endfunction

  // Diagonal one, off-diagonal zero
  function automatic logic is_identity(input logic [8:0][ENTRY_BITS-1:0] e);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 9; k++) begin
      ok = ok && (e[k] == ((k % 4 == 0) ? ENTRY_BITS'(ONE_Q14) : '0));
    end
    return ok;
  endfunction

  `QRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ent), "output dropped while stalled")
  `QRM_ASSERT(a_degen_identity, out_valid && out_degen |-> is_identity(ent), "degenerate result is not identity")
  `QRM_ASSERT(a_entry_range, out_valid |-> all_in_range(ent), "matrix entry out of range")
  `QRM_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_quat.ready),
  .out_valid (out_mat.valid),
  .out_ready (out_mat.ready),
  .out_degen (out_mat.degenerate),
  .ent       ({out_mat.row0_col0, out_mat.row0_col1, out_mat.row0_col2,
               out_mat.row1_col0, out_mat.row1_col1, out_mat.row1_col2,
               out_mat.row2_col0, out_mat.row2_col1, out_mat.row2_col2})
);

>>> bench/tb_quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_rotation_matrix
// Streams quaternions through the block with random gaps on both sides and
// checks every matrix entry and the degenerate flag against a local predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix;
  import qrm_pkg::*;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_t;

  typedef struct packed {
    logic [8:0][15:0] entry;
    logic             degen;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;

  qrm_quat_if #(.CB(16)) quat_ch ();
  qrm_mat_if             mat_ch ();

  quaternion_to_rotation_matrix #(.COMPONENT_BITS(16)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_quat (quat_ch.sink),
    .out_mat (mat_ch.source)
  );

  always #5 clk = ~clk;

  quat_t   pending_quats[$];
  matrix_t expected_mats[$];
  bit      stim_done = 1'b0;

  // Rounded, saturated Q1.14 ratio of num over den by restoring division
  function automatic logic [15:0] ratio_q14(longint num, longint unsigned den);
    logic             neg;
    longint unsigned  mag, q, rem;
    longint           res;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    q = 0;
    if (mag >= den) begin
      q = 1;
      rem = mag - den;
      if (rem >= den) rem = 0;
    end else begin
      rem = mag;
    end
    for (int i = 0; i < 15; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    q = (q + 1) >> 1;
    if (q > ONE_Q14) q = ONE_Q14;
    res = neg ? -longint'(q) : longint'(q);
    return res[15:0];
  endfunction

  // Predict the rotation matrix of one quaternion
  function automatic matrix_t rotation_of(quat_t q);
    matrix_t m;
    longint x, y, z, w, xx, yy, zz, ww;
    longint unsigned n;
    x = q.qx; y = q.qy; z = q.qz; w = q.qw;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n = xx + yy + zz + ww;
    if (n == 0) begin
      for (int i = 0; i < 9; i++) m.entry[i] = (i % 4 == 0) ? 16'(ONE_Q14) : 16'd0;
      m.degen = 1'b1;
      return m;
    end
    m.entry[0] = ratio_q14(ww + xx - yy - zz, n);
    m.entry[1] = ratio_q14(2 * (x * y - w * z), n);
    m.entry[2] = ratio_q14(2 * (x * z + w * y), n);
    m.entry[3] = ratio_q14(2 * (x * y + w * z), n);
    m.entry[4] = ratio_q14(ww - xx + yy - zz, n);
    m.entry[5] = ratio_q14(2 * (y * z - w * x), n);
    m.entry[6] = ratio_q14(2 * (x * z - w * y), n);
    m.entry[7] = ratio_q14(2 * (y * z + w * x), n);
    m.entry[8] = ratio_q14(ww - xx - yy + zz, n);
    m.degen = 1'b0;
    return m;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic quat_t mk(int a, int b, int c, int d);
    quat_t q;
    q.qx = 16'(a); q.qy = 16'(b); q.qz = 16'(c); q.qw = 16'(d);
    return q;
  endfunction

  // Fill the queue: directed corners first, then random quaternions
  initial begin
    quat_t q;
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, 4096));
    pending_quats.push_back(mk(4096, 0, 0, 0));
    pending_quats.push_back(mk(0, 4096, 0, 0));
    pending_quats.push_back(mk(0, 0, 4096, 0));
    pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mk(32767, 32767, 32767, 32767));
    pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
    pending_quats.push_back(mk(1, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, -1));
    pending_quats.push_back(mk(1, -1, 1, -1));
    pending_quats.push_back(mk(-32768, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 32767, -32768));
    pending_quats.push_back(mk(2896, 0, 0, 2896));
    pending_quats.push_back(mk(0, -2896, 0, 2896));
    pending_quats.push_back(mk(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    for (int i = 0; i < 950; i++) begin
      q.qx = rand_comp(); q.qy = rand_comp(); q.qz = rand_comp(); q.qw = rand_comp();
      if ($urandom_range(0, 40) == 0) q = '0;
      pending_quats.push_back(q);
    end
    stim_done = 1'b1;
  end

  // Drive quaternions with a random gap before each transaction
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      quat_ch.valid <= 1'b0;
      quat_ch.quat_x <= '0; quat_ch.quat_y <= '0;
      quat_ch.quat_z <= '0; quat_ch.quat_w <= '0;
      src_gap <= $urandom_range(0, 12);
    end else if (!quat_ch.valid || quat_ch.ready) begin
      if (quat_ch.valid) expected_mats.push_back(rotation_of(
        {quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z, quat_ch.quat_w}));
      if (src_gap > 0 || pending_quats.size() == 0) begin
        quat_ch.valid <= 1'b0;
        if (src_gap > 0) src_gap <= src_gap - 1;
      end else begin
        quat_t q;
        q = pending_quats.pop_front();
        quat_ch.valid <= 1'b1;
        quat_ch.quat_x <= q.qx; quat_ch.quat_y <= q.qy;
        quat_ch.quat_z <= q.qz; quat_ch.quat_w <= q.qw;
        // half the time stream back to back
        src_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  // Check each accepted matrix and draw the next stall
  int sink_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      mat_ch.ready <= 1'b0;
      sink_gap <= $urandom_range(0, 12);
    end else begin
      if (mat_ch.valid && mat_ch.ready) begin
        matrix_t got, want;
        got.entry = {mat_ch.row2_col2, mat_ch.row2_col1, mat_ch.row2_col0,
                     mat_ch.row1_col2, mat_ch.row1_col1, mat_ch.row1_col0,
                     mat_ch.row0_col2, mat_ch.row0_col1, mat_ch.row0_col0};
        got.degen = mat_ch.degenerate;
        if (expected_mats.size() == 0) begin
          $error("unexpected matrix transaction");
          failed = 1'b1;
        end else begin
          want = expected_mats.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.entry[i] !== want.entry[i]) begin
              $error("row%0d_col%0d: expected %0d, got %0d", i / 3, i % 3,
                     $signed(want.entry[i]), $signed(got.entry[i]));
              failed = 1'b1;
            end
          if (got.degen !== want.degen) begin
            $error("degenerate: expected %0b, got %0b", want.degen, got.degen);
            failed = 1'b1;
          end
        end
      end
      if (sink_gap > 0) begin
        mat_ch.ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else begin
        mat_ch.ready <= 1'b1;
        if (mat_ch.valid)
          sink_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  // Reset, then wait for the stream to drain
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_quats.size() != 0 || quat_ch.valid || expected_mats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
